// ===== src/ufh_pkg.sv =====
// Shared types and constants for the UTF-8 full-width to half-width converter.
`default_nettype none

package ufh_pkg;

  // Output queue geometry
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Most bytes one input byte can release
  localparam int MaxOut = 3;
  localparam int OutCntW = $clog2(MaxOut + 1);

  // Lead byte detection
  localparam logic [7:0] LeadMask  = 8'hF0;
  localparam logic [7:0] LeadValue = 8'hE0;
  localparam logic [7:0] TailMask  = 8'h3F;

  // Code points
  localparam logic [15:0] CodeSpace  = 16'h3000;
  localparam logic [15:0] CodeFwLow  = 16'hFF01;
  localparam logic [15:0] CodeFwHigh = 16'hFF5E;
  localparam logic [15:0] FwOffset   = 16'hFEE0;

  // Half-width bytes
  localparam logic [7:0] ByteSpace    = 8'h20;
  localparam logic [7:0] ByteComma    = 8'h2C;
  localparam logic [7:0] ByteQuestion = 8'h3F;
  localparam logic [7:0] ByteExclaim  = 8'h21;

  // Group tracking state
  typedef enum logic [2:0] {
    PhIdle   = 3'b001,
    PhLead   = 3'b010,
    PhSecond = 3'b100
  } phase_e;

  // Bytes released by one input byte, pushed into the output queue at once
  typedef struct packed {
    logic                         valid;
    logic [OutCntW-1:0]           cnt;
    logic [MaxOut-1:0][7:0]       data;
    logic [MaxOut-1:0]            last;
  } push_t;

endpackage

`default_nettype wire

// ===== src/ufh_decode.sv =====
// Input register, group tracking and byte conversion.
`default_nettype none

module ufh_decode (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [7:0]              in_byte_i,
  input  wire logic                    in_last_i,
  input  wire logic [ufh_pkg::QCntW-1:0] room_i,
  output ufh_pkg::push_t               push_o
);
  import ufh_pkg::*;

  logic         in_valid_q;
  logic [7:0]   byte_q;
  logic         last_q;
  phase_e       phase_q, phase_d;
  logic [7:0]   lead_q, lead_d;
  logic [7:0]   second_q, second_d;
  logic         advance;
  logic [15:0]  code;
  logic [15:0]  diff;
  logic [7:0]   single;
  logic         is_fw;
  logic         keep_group;
  push_t        push;

  // Decode the 16-bit code of a complete group
  assign code   = {lead_q[3:0], second_q[5:0], byte_q[5:0]};
  assign diff   = code - FwOffset;
  assign single = (code == CodeSpace) ? ByteSpace : diff[7:0];
  assign is_fw  = (code >= CodeFwLow) && (code <= CodeFwHigh);
  assign keep_group = !((code == CodeSpace) ||
                        (is_fw && !(single == ByteComma || single == ByteQuestion ||
                                    single == ByteExclaim)));

  // Work out the released bytes and the next group state
  always_comb begin
    phase_d   = phase_q;
    lead_d    = lead_q;
    second_d  = second_q;
    push      = '0;
    case (phase_q)
      PhLead: begin
        if (last_q) begin
          push.cnt     = OutCntW'(2);
          push.data[0] = lead_q;
          push.data[1] = byte_q;
          push.last[1] = 1'b1;
          phase_d      = PhIdle;
        end else begin
          second_d = byte_q;
          phase_d  = PhSecond;
        end
      end
      PhSecond: begin
        if (keep_group) begin
          push.cnt     = OutCntW'(3);
          push.data[0] = lead_q;
          push.data[1] = second_q;
          push.data[2] = byte_q;
          push.last[2] = last_q;
        end else begin
          push.cnt     = OutCntW'(1);
          push.data[0] = single;
          push.last[0] = last_q;
        end
        phase_d = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
        if (((byte_q & LeadMask) == LeadValue) && !last_q) begin
          lead_d  = byte_q;
          phase_d = PhLead;
        end else begin
          push.cnt     = OutCntW'(1);
          push.data[0] = byte_q;
          push.last[0] = last_q;
        end
      end
    endcase
  end

  // Move on once the queue can take every byte of this transaction
  assign advance     = in_valid_q && (room_i >= QCntW'(push.cnt));
  assign in_stall_o  = in_valid_q && !advance;

  always_comb begin
    push_o       = push;
    push_o.valid = advance;
  end

  // Hold the input transaction until it advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  // Advance the group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      lead_q   <= '0;
      second_q <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      lead_q   <= lead_d;
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ufh_outq.sv =====
// Output byte queue: takes up to three bytes a cycle, hands out one unless the output stalls.
`default_nettype none

module ufh_outq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ufh_pkg::push_t            push_i,
  output logic [ufh_pkg::QCntW-1:0]      room_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_last_o
);
  import ufh_pkg::*;

  logic [7:0]       data_q [QDepth];
  logic             last_q [QDepth];
  logic [QAw-1:0]   wr_q, rd_q;
  logic [QCntW-1:0] count_q;
  logic             pop;
  logic [QCntW-1:0] push_cnt;

  assign pop         = (count_q != '0) && !out_stall_i;
  assign push_cnt    = push_i.valid ? QCntW'(push_i.cnt) : '0;
  assign room_o      = QCntW'(QDepth) - count_q + QCntW'(pop);
  assign out_valid_o = (count_q != '0);
  assign out_byte_o  = data_q[rd_q];
  assign out_last_o  = last_q[rd_q];

  // Write the released bytes into free slots
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxOut; k++) begin
      if (push_i.valid && (OutCntW'(k) < push_i.cnt)) begin
        data_q[wr_q + QAw'(k)] <= push_i.data[k];
        last_q[wr_q + QAw'(k)] <= push_i.last[k];
      end
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + QAw'(push_cnt);
      rd_q    <= rd_q + QAw'(pop);
      count_q <= count_q + push_cnt - QCntW'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/utf8_fullwidth_to_halfwidth.sv =====
// Top level of the UTF-8 full-width to half-width converter.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o   | in_byte_i, in_last_i
//   out     | output    | out_valid_o / out_stall_i | out_byte_o, out_last_o
//
// One input byte is taken per cycle unless the input stalls; each byte is
// registered at the input before it is queued. A complete group releases up
// to three bytes at once into a four-entry queue, which drains one byte a
// cycle unless the output stalls. The input stalls only while the queue lacks
// room for the held transaction. Reset clears the group state and the queue.
`default_nettype none

module utf8_fullwidth_to_halfwidth (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import ufh_pkg::*;

  push_t            push;
  logic [QCntW-1:0] room;

  ufh_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .room_i     (room),
    .push_o     (push)
  );

  ufh_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

// ===== src/ufh_checker.sv =====
// Port-level checks for the converter, bound to the top level.
`default_nettype none

module ufh_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_i,
  input wire logic       out_valid_i,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);

  // Hold a stalled output transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled output transaction changed");

  // Never stall the input while the output side is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> !in_stall_i)
    else $error("input stalled with empty output queue");

  // Output data appears only once an accepted input transaction has been registered and queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && !in_stall_i, 2))
    else $error("output appeared without a matching input transaction");

endmodule

bind utf8_fullwidth_to_halfwidth ufh_checker u_ufh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_i  (out_byte_o),
  .out_last_i  (out_last_o)
);

`default_nettype wire
